// File: rtl/iopr_pkg.sv
// ----------------------------------------------------------------------------
// iopr_pkg
// Shared types, constants and the CRC byte function of the in-order packet receiver.
// ----------------------------------------------------------------------------
package iopr_pkg;

	localparam int unsigned SEQ_WIDTH_DEF = 31;
	localparam int unsigned PERIOD_W      = 31;
	localparam int unsigned CFG_IDX_W     = 8;
	localparam int unsigned CFG_DATA_W    = 32;
	localparam int unsigned CRC_W         = 16;
	localparam int unsigned CHK_W         = 64;
	localparam int unsigned ASEQ_W        = 31;
	localparam int unsigned DEC_DIGITS    = 10;
	localparam int unsigned BCD_W         = 4 * DEC_DIGITS;
	localparam int unsigned SUM_W         = 16;
	localparam int unsigned WT_W          = 4;
	localparam int unsigned IN_DATA_W     = 104;
	localparam int unsigned OUT_DATA_W    = 96;
	localparam int unsigned OUT_USER_W    = 3;

	localparam logic [CRC_W-1:0]     CRC_INIT     = 16'hFFFF;
	localparam logic [CRC_W-1:0]     CRC_POLY     = 16'hA001;
	localparam logic [CHK_W-1:0]     CORRUPT_DROP = 64'd1000;
	localparam logic [7:0]           ASCII_ZERO   = 8'd48;
	localparam logic [PERIOD_W-1:0]  PERIOD_RST   = 31'h7FFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] REG_DROP_PERIOD    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CORRUPT_PERIOD = 8'd1;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT  = 2'd0,
		VERDICT_ORDER   = 2'd1,
		VERDICT_CORRUPT = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_SUM,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic byte_en;
		logic pkt_end;
		logic start;
		logic calc_step;
		logic sum_step;
		logic load_reject;
		logic load_ack;
	} ctl_cmd_t;

	typedef struct packed {
		logic pkt_good;
	} dp_stat_t;

	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
		input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

// File: rtl/in_order_packet_receiver_unit.sv
// ----------------------------------------------------------------------------
// in_order_packet_receiver_unit
// In-order packet receiver: CRC-16 check, sequence check, ACK generation.
// ----------------------------------------------------------------------------
// Non-last beats: one per cycle while the receiver is idle, no result.
// Rejected packet: verdict beat valid in the cycle after the last input beat is taken.
// Accepted packet: result after a remainder/BCD loop of SEQ_WIDTH steps, ten
// digit-sum steps and one load; input is held off meanwhile.
// Reset: asynchronous, expected sequence 1, both periods 2^31-1, no result.
module in_order_packet_receiver_unit #(
	parameter int unsigned SEQ_WIDTH = iopr_pkg::SEQ_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [iopr_pkg::IN_DATA_W-1:0]     s_tdata,  // data_byte, packet_sequence, packet_checksum
	input  logic                               s_tlast,  // byte_last
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [iopr_pkg::OUT_DATA_W-1:0]    m_tdata,  // ack_sequence, ack checksum, pad
	output logic [iopr_pkg::OUT_USER_W-1:0]    m_tuser,  // verdict, ack_send
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [iopr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [iopr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import iopr_pkg::*;

	ctl_cmd_t            cmd;
	dp_stat_t            stat;
	logic [1:0]          verdict;
	logic                ack_send;
	logic [ASEQ_W-1:0]   ack_sequence;
	logic [CHK_W-1:0]    ack_chk;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {1'b0, ack_chk, ack_sequence};
	assign m_tuser   = {ack_send, verdict};

	iopr_ctrl #(.SEQ_WIDTH(SEQ_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	iopr_datapath #(.SEQ_WIDTH(SEQ_WIDTH)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.data_byte       (s_tdata[7:0]),
		.packet_sequence (s_tdata[39:8]),
		.packet_checksum (s_tdata[103:40]),
		.verdict         (verdict),
		.ack_send        (ack_send),
		.ack_sequence    (ack_sequence),
		.ack_chk         (ack_chk)
	);

endmodule

// File: rtl/iopr_datapath.sv
// ----------------------------------------------------------------------------
// iopr_datapath
// CRC, sequence tracking, period remainders, decimal digit checksum, result.
// ----------------------------------------------------------------------------
module iopr_datapath #(
	parameter int unsigned SEQ_WIDTH = iopr_pkg::SEQ_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  iopr_pkg::ctl_cmd_t                cmd,
	output iopr_pkg::dp_stat_t                stat,
	input  logic                              cfg_we,
	input  logic [iopr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [iopr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [7:0]                        data_byte,
	input  logic [31:0]                       packet_sequence,
	input  logic [iopr_pkg::CHK_W-1:0]        packet_checksum,
	output logic [1:0]                        verdict,
	output logic                              ack_send,
	output logic [iopr_pkg::ASEQ_W-1:0]       ack_sequence,
	output logic [iopr_pkg::CHK_W-1:0]        ack_chk
);
	import iopr_pkg::*;

	logic [PERIOD_W-1:0]  drop_per_q, corr_per_q;
	logic [SEQ_WIDTH-1:0] exp_seq_q;
	logic [CRC_W-1:0]     crc_q, crc_nxt;
	logic [7:0]           held_q;
	logic                 held_vld_q, ended_q;

	logic [SEQ_WIDTH-1:0] dvd_q, bin_q;
	logic [PERIOD_W-1:0]  rem_drop_q, rem_corr_q;
	logic [PERIOD_W:0]    trial_drop, trial_corr;
	logic [BCD_W-1:0]     bcd_q, bcd_adj;
	logic [SUM_W-1:0]     sum_q, sum_fix;
	logic [WT_W-1:0]      wt_q;
	logic                 started_q, dig_on;
	logic [3:0]           dig;
	logic                 do_drop, do_corr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_per_q <= PERIOD_RST;
			corr_per_q <= PERIOD_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_DROP_PERIOD)
				drop_per_q <= cfg_data[PERIOD_W-1:0];
			else if (cfg_index == REG_CORRUPT_PERIOD)
				corr_per_q <= cfg_data[PERIOD_W-1:0];
		end
	end

	// running CRC trails one byte behind the string
	always_comb begin
		crc_nxt = crc_q;
		if (!ended_q && data_byte != 8'h00 && held_vld_q)
			crc_nxt = crc_feed(crc_q, held_q);
	end

	assign stat.pkt_good = (packet_checksum == {{(CHK_W-CRC_W){1'b0}}, crc_nxt}) &&
		(packet_sequence == {{(32-SEQ_WIDTH){1'b0}}, exp_seq_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			held_q     <= 8'h00;
			held_vld_q <= 1'b0;
			ended_q    <= 1'b0;
		end else if (cmd.byte_en) begin
			if (cmd.pkt_end) begin
				crc_q      <= CRC_INIT;
				held_q     <= 8'h00;
				held_vld_q <= 1'b0;
				ended_q    <= 1'b0;
			end else if (!ended_q) begin
				if (data_byte == 8'h00) begin
					ended_q <= 1'b1;
				end else begin
					crc_q      <= crc_nxt;
					held_q     <= data_byte;
					held_vld_q <= 1'b1;
				end
			end
		end
	end

	// restoring remainder against both periods, binary to BCD alongside
	assign trial_drop = {rem_drop_q, dvd_q[SEQ_WIDTH-1]};
	assign trial_corr = {rem_corr_q, dvd_q[SEQ_WIDTH-1]};

	always_comb begin
		for (int n = 0; n < DEC_DIGITS; n++) begin
			if (bcd_q[4*n +: 4] >= 4'd5)
				bcd_adj[4*n +: 4] = bcd_q[4*n +: 4] + 4'd3;
			else
				bcd_adj[4*n +: 4] = bcd_q[4*n +: 4];
		end
	end

	assign dig    = bcd_q[BCD_W-1 -: 4];
	assign dig_on = started_q || (dig != 4'd0);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q      <= exp_seq_q;
			bin_q      <= exp_seq_q;
			rem_drop_q <= '0;
			rem_corr_q <= '0;
			bcd_q      <= '0;
			sum_q      <= '0;
			wt_q       <= '0;
			started_q  <= 1'b0;
		end else if (cmd.calc_step) begin
			dvd_q <= dvd_q << 1;
			if (trial_drop >= {1'b0, drop_per_q})
				rem_drop_q <= PERIOD_W'(trial_drop - {1'b0, drop_per_q});
			else
				rem_drop_q <= trial_drop[PERIOD_W-1:0];
			if (trial_corr >= {1'b0, corr_per_q})
				rem_corr_q <= PERIOD_W'(trial_corr - {1'b0, corr_per_q});
			else
				rem_corr_q <= trial_corr[PERIOD_W-1:0];
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[SEQ_WIDTH-1]};
			bin_q <= bin_q << 1;
		end else if (cmd.sum_step) begin
			bcd_q <= bcd_q << 4;
			if (dig_on) begin
				sum_q     <= sum_q + (SUM_W'({4'd0, dig} + ASCII_ZERO) << wt_q);
				wt_q      <= wt_q + WT_W'(1);
				started_q <= 1'b1;
			end
		end
	end

	// a zero sequence is the single digit "0"
	assign sum_fix = (sum_q == '0) ? SUM_W'(ASCII_ZERO) : sum_q;

	assign do_drop = (drop_per_q != '0) && (rem_drop_q == '0);
	assign do_corr = (corr_per_q != '0) && (rem_corr_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exp_seq_q <= SEQ_WIDTH'(1);
		else if (cmd.load_ack)
			exp_seq_q <= exp_seq_q + SEQ_WIDTH'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_reject) begin
			verdict      <= (packet_sequence != {{(32-SEQ_WIDTH){1'b0}}, exp_seq_q}) ?
				VERDICT_ORDER : VERDICT_CORRUPT;
			ack_send     <= 1'b0;
			ack_sequence <= '0;
			ack_chk      <= '0;
		end else if (cmd.load_ack) begin
			verdict  <= VERDICT_ACCEPT;
			ack_send <= !do_drop;
			if (do_drop) begin
				ack_sequence <= '0;
				ack_chk      <= '0;
			end else begin
				ack_sequence <= ASEQ_W'(exp_seq_q);
				ack_chk      <= {{(CHK_W-SUM_W){1'b0}}, sum_fix} -
					(do_corr ? CORRUPT_DROP : '0);
			end
		end
	end

endmodule

// File: rtl/iopr_ctrl.sv
// ----------------------------------------------------------------------------
// iopr_ctrl
// Sequencer: byte intake, end-of-packet calculation steps, output beat valid.
// ----------------------------------------------------------------------------
module iopr_ctrl #(
	parameter int unsigned SEQ_WIDTH = iopr_pkg::SEQ_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  iopr_pkg::dp_stat_t stat,
	output iopr_pkg::ctl_cmd_t cmd
);
	import iopr_pkg::*;

	localparam int unsigned CNT_W = ($clog2(SEQ_WIDTH) > $clog2(DEC_DIGITS)) ?
		$clog2(SEQ_WIDTH) : $clog2(DEC_DIGITS);

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             out_vld_q, out_free, acc, cnt_last;

	assign out_free  = !out_vld_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && (!in_last || out_free);
	assign acc       = in_valid && in_ready;
	assign out_valid = out_vld_q;

	always_comb begin
		case (state_q)
			ST_CALC: cnt_last = (cnt_q == CNT_W'(SEQ_WIDTH - 1));
			ST_SUM:  cnt_last = (cnt_q == CNT_W'(DEC_DIGITS - 1));
			default: cnt_last = 1'b0;
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (acc && in_last && stat.pkt_good) state_nxt = ST_CALC;
			ST_CALC: if (cnt_last) state_nxt = ST_SUM;
			ST_SUM:  if (cnt_last) state_nxt = ST_FIN;
			ST_FIN:  state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.byte_en     = acc;
				cmd.pkt_end     = acc && in_last;
				cmd.start       = acc && in_last && stat.pkt_good;
				cmd.load_reject = acc && in_last && !stat.pkt_good;
			end
			ST_CALC: cmd.calc_step = 1'b1;
			ST_SUM:  cmd.sum_step = 1'b1;
			ST_FIN:  cmd.load_ack = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q != state_nxt)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + CNT_W'(1);
			if (cmd.load_reject || cmd.load_ack)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input ready while busy");
	a_ack_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_ack |-> !out_vld_q)
		else $error("result overwritten");
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.load_reject, cmd.load_ack}))
		else $error("conflicting loads");
	a_start_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_CALC) && (cnt_q == '0))
		else $error("calculation did not start");
`endif

endmodule

// File: tb/sv/in_order_packet_receiver_checker.sv
// ----------------------------------------------------------------------------
// in_order_packet_receiver_checker
// Watches the config, input and result channels of the packet receiver,
// predicts the verdict and ACK of every packet and compares each result beat.
// ----------------------------------------------------------------------------
module in_order_packet_receiver_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [iopr_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                             s_tlast,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [iopr_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic [iopr_pkg::OUT_USER_W-1:0]  m_tuser,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [iopr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [iopr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               errors,
	output int                               pending,
	output int                               n_acked,
	output int                               n_dropped,
	output int                               n_rejected
);
	timeunit 1ns;
	timeprecision 1ps;
	import iopr_pkg::*;

	typedef struct {
		verdict_t          verdict;
		bit                ack_send;
		bit [ASEQ_W-1:0]   ack_seq;
		bit [CHK_W-1:0]    ack_chk;
	} ack_result_t;

	ack_result_t        verdict_q[$];
	bit [30:0]          seq_expected;
	bit [PERIOD_W-1:0]  drop_period;
	bit [PERIOD_W-1:0]  corrupt_period;
	bit [CRC_W-1:0]     crc_acc;
	bit [7:0]           byte_held;
	bit                 byte_held_v;
	bit                 str_done;

	assign pending = verdict_q.size();

	function automatic bit [CRC_W-1:0] fold_crc_byte(bit [CRC_W-1:0] c, bit [7:0] b);
		c ^= {8'h00, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction

	// digits from the most significant, weighted 1, 2, 4, ...
	function automatic bit [CHK_W-1:0] ascii_digit_sum(bit [30:0] v);
		int         digs[$];
		bit [63:0]  sum;
		sum = 0;
		do begin
			digs.push_front(v % 10);
			v = v / 10;
		end while (v != 0);
		foreach (digs[i])
			sum += 64'(digs[i] + 48) << i;
		return sum;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		if (errors <= 30)
			$display("%0t MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		ack_result_t  r;
		bit [7:0]     b;
		bit [31:0]    hdr_seq;
		bit [63:0]    hdr_chk;
		bit [CRC_W-1:0] crc_final;
		if (!arst_n) begin
			verdict_q.delete();
			seq_expected   = 1;
			drop_period    = PERIOD_RST;
			corrupt_period = PERIOD_RST;
			crc_acc        = CRC_INIT;
			byte_held      = 0;
			byte_held_v    = 0;
			str_done       = 0;
			errors         = 0;
			n_acked        = 0;
			n_dropped      = 0;
			n_rejected     = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DROP_PERIOD)
					drop_period = cfg_data[PERIOD_W-1:0];
				else if (cfg_index == REG_CORRUPT_PERIOD)
					corrupt_period = cfg_data[PERIOD_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					report("unexpected result beat", {m_tuser, m_tdata[60:0]}, 0);
				end else begin
					r = verdict_q.pop_front();
					if (m_tuser[1:0] != r.verdict)
						report("verdict", m_tuser[1:0], r.verdict);
					if (m_tuser[2] != r.ack_send)
						report("ack_send", m_tuser[2], r.ack_send);
					if (m_tdata[30:0] != r.ack_seq)
						report("ack_sequence", m_tdata[30:0], r.ack_seq);
					if (m_tdata[94:31] != r.ack_chk)
						report("ack checksum", m_tdata[94:31], r.ack_chk);
				end
			end
			if (s_tvalid && s_tready) begin
				b       = s_tdata[7:0];
				hdr_seq = s_tdata[39:8];
				hdr_chk = s_tdata[103:40];
				if (!str_done) begin
					if (b == 0) begin
						str_done = 1;
					end else begin
						if (byte_held_v)
							crc_acc = fold_crc_byte(crc_acc, byte_held);
						byte_held   = b;
						byte_held_v = 1;
					end
				end
				if (s_tlast) begin
					crc_final   = crc_acc;
					crc_acc     = CRC_INIT;
					byte_held   = 0;
					byte_held_v = 0;
					str_done    = 0;
					r = '{VERDICT_ACCEPT, 0, 0, 0};
					if (hdr_seq != {1'b0, seq_expected}) begin
						r.verdict = VERDICT_ORDER;
						n_rejected++;
					end else if (hdr_chk != {48'h0, crc_final}) begin
						r.verdict = VERDICT_CORRUPT;
						n_rejected++;
					end else begin
						if (drop_period != 0 && seq_expected % drop_period == 0) begin
							n_dropped++;
						end else begin
							r.ack_send = 1;
							r.ack_seq  = seq_expected;
							r.ack_chk  = ascii_digit_sum(seq_expected);
							if (corrupt_period != 0 && seq_expected % corrupt_period == 0)
								r.ack_chk -= 64'd1000;
							n_acked++;
						end
						seq_expected = seq_expected + 1;
					end
					verdict_q.push_back(r);
				end
			end
		end
	end

endmodule

// File: tb/sv/in_order_packet_receiver_unit_test.sv
// ----------------------------------------------------------------------------
// in_order_packet_receiver_unit_test
// Drives packets, period settings and receiver back-pressure into the packet
// receiver; the checker predicts and compares every verdict beat.
// ----------------------------------------------------------------------------
module in_order_packet_receiver_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import iopr_pkg::*;

	typedef enum {PK_GOOD, PK_BAD_SEQ, PK_BAD_CHK, PK_BOTH, PK_SEQ_TOP, PK_SEQ_ZERO} pkt_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int  errors, pending, n_acked, n_dropped, n_rejected;
	int  n_beats;
	bit  quiet;
	bit  hold_req;
	bit [31:0] seq_next;

	in_order_packet_receiver_unit u_top (.*);

	in_order_packet_receiver_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int gap;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			gap = quiet ? 0 : $urandom_range(0, 5);
			if (hold_req) begin
				hold_req = 0;
				gap = 400;
			end
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do @(negedge clk); while (!m_tvalid);
		end
	end

	function automatic bit [15:0] packet_crc(bit [7:0] bytes[$]);
		bit [15:0] c;
		int        n;
		c = 16'hFFFF;
		n = 0;
		while (n < bytes.size() && bytes[n] != 0)
			n++;
		for (int i = 0; i < n - 1; i++) begin
			c ^= {8'h00, bytes[i]};
			for (int k = 0; k < 8; k++)
				c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	task automatic send_beat(bit [7:0] b, bit [31:0] seq, bit [63:0] chk, bit last);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {chk, seq, b};
		s_tlast  <= last;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		n_beats++;
	endtask

	task automatic send_pkt(bit [7:0] bytes[$], pkt_kind_t kind);
		bit [15:0] crc;
		bit [31:0] seq;
		bit [63:0] chk;
		crc = packet_crc(bytes);
		seq = seq_next;
		chk = {48'h0, crc};
		if (kind == PK_BAD_SEQ || kind == PK_BOTH) begin
			seq = ($urandom_range(0, 1)) ? seq_next + $urandom_range(1, 3) : $urandom;
			if (seq == seq_next)
				seq++;
		end
		if (kind == PK_BAD_CHK || kind == PK_BOTH) begin
			chk = ($urandom_range(0, 1)) ? {48'h0, crc ^ 16'(1 << $urandom_range(0, 15))}
				: {$urandom, $urandom};
			if (chk == {48'h0, crc})
				chk[0] = ~chk[0];
		end
		if (kind == PK_SEQ_TOP) begin
			seq = 32'hFFFF_FFFF;
			chk = '1;
		end
		if (kind == PK_SEQ_ZERO) begin
			seq = 0;
			chk = 0;
		end
		if (kind == PK_GOOD || kind == PK_BAD_CHK)
			seq_next = seq_next + (kind == PK_GOOD);
		foreach (bytes[i])
			if (i == bytes.size() - 1)
				send_beat(bytes[i], seq, chk, 1);
			else
				send_beat(bytes[i], $urandom, {$urandom, $urandom}, 0);
	endtask

	task automatic random_pkt();
		bit [7:0]  bytes[$];
		int        len;
		int        pick;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
		for (int i = 0; i < len; i++)
			bytes.push_back(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
		pick = $urandom_range(0, 99);
		send_pkt(bytes, pick < 70 ? PK_GOOD : pick < 80 ? PK_BAD_SEQ :
			pick < 90 ? PK_BAD_CHK : PK_BOTH);
	endtask

	task automatic settle();
		s_tvalid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	initial begin
		s_tvalid  = 0;
		s_tdata   = 0;
		s_tlast   = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data  = 0;
		quiet     = 0;
		hold_req  = 0;
		seq_next  = 1;
		n_beats   = 0;
		arst_n    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed packets under reset periods
		send_pkt('{8'h00}, PK_GOOD);
		send_pkt('{8'h5A}, PK_GOOD);
		send_pkt('{8'hFF, 8'hFF, 8'hFF}, PK_GOOD);
		send_pkt('{8'h41, 8'h00, 8'h55, 8'h80}, PK_GOOD);
		send_pkt('{8'h01, 8'h02}, PK_SEQ_TOP);
		send_pkt('{8'h12, 8'h34}, PK_SEQ_ZERO);
		send_pkt('{8'h7E, 8'h81, 8'h00}, PK_BAD_CHK);
		send_pkt('{8'h10, 8'h20, 8'h30}, PK_BOTH);
		send_pkt('{8'hFF, 8'h01, 8'hAA, 8'h55}, PK_GOOD);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
			1: begin
				write_reg(REG_DROP_PERIOD, 3);
				write_reg(REG_CORRUPT_PERIOD, 2);
			end
			2: begin
				write_reg(REG_DROP_PERIOD, 0);
				write_reg(REG_CORRUPT_PERIOD, 1);
				hold_req = 1;
			end
			3: begin
				write_reg(REG_DROP_PERIOD, 1);
				write_reg(REG_CORRUPT_PERIOD, 0);
				quiet = 1;
			end
			4: begin
				quiet = 0;
				write_reg(REG_DROP_PERIOD, 32'hFFFF_FFFF);
				write_reg(REG_CORRUPT_PERIOD, $urandom_range(2, 9));
			end
			5: begin
				write_reg(REG_DROP_PERIOD, $urandom_range(2, 6));
				write_reg(REG_CORRUPT_PERIOD, 32'h7FFF_FFFF);
			end
			default: ;
			endcase
			repeat (38) random_pkt();
			settle();
		end

		$display("Covered %0d input beats: %0d ACKs sent, %0d dropped, %0d packets rejected,",
			n_beats, n_acked, n_dropped, n_rejected);
		$display("across six period settings with long back-pressure and idle-free stretches.");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
rtl/iopr_pkg.sv
rtl/iopr_datapath.sv
rtl/iopr_ctrl.sv
rtl/in_order_packet_receiver_unit.sv
tb/sv/in_order_packet_receiver_checker.sv
tb/sv/in_order_packet_receiver_unit_test.sv
